// ===== design/rmbm_pkg.sv =====
// Shared types and constants for the region mapped byte memory.
// Used by rmbm_ctrl, rmbm_datapath and region_mapped_byte_memory; no dependencies.
package rmbm_pkg;

   // region count is fixed by the register map
   localparam int NUM_REGIONS = 2;
   localparam int REG_W       = 1;

   // configuration port
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // field widths
   localparam int FUNC_W      = 2;
   localparam int ADDR_W      = 32;
   localparam int LEN_W       = 3;
   localparam int DATA_W      = 32;
   localparam int FAULT_W     = 3;
   localparam int SIZE_W      = 13;
   localparam int PERM_W      = 3;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;

   // operations
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;

   // fault codes
   localparam logic [FAULT_W-1:0] FAULT_NONE     = 3'd0;
   localparam logic [FAULT_W-1:0] FAULT_READ     = 3'd1;
   localparam logic [FAULT_W-1:0] FAULT_WRITE    = 3'd2;
   localparam logic [FAULT_W-1:0] FAULT_UNMAPPED = 3'd3;
   localparam logic [FAULT_W-1:0] FAULT_RANGE    = 3'd4;

   // permission bits
   localparam int PERM_READ  = 0;
   localparam int PERM_WRITE = 1;

   // register indexes
   localparam logic [2:0] REG_R0_BASE  = 3'd0;
   localparam logic [2:0] REG_R0_SIZE  = 3'd1;
   localparam logic [2:0] REG_R0_PERMS = 3'd2;
   localparam logic [2:0] REG_R1_BASE  = 3'd3;
   localparam logic [2:0] REG_R1_SIZE  = 3'd4;
   localparam logic [2:0] REG_R1_PERMS = 3'd5;

   localparam logic [7:0] BYTE_MASK = 8'hFF;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
      logic [PERM_W-1:0] perms;
   } region_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic clear;   // clear one entry in each byte store
      logic accept;  // take the request word
      logic step;    // handle one byte
      logic finish;  // load the response register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;  // last entry of the clearing pass
      logic stop;        // this byte ends the access
      logic out_free;    // response register can take a word
   } dp_sts_type;

endpackage

// ===== design/rmbm_store.sv =====
// One region's byte store: single address port, registered read data.
// No dependencies.
module rmbm_store #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [7:0]               wdata,
   output logic [7:0]               rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/rmbm_ctrl.sv =====
// Controller: clearing pass, accept, byte steps and response hand-off.
// Depends on rmbm_pkg.
module rmbm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rmbm_pkg::dp_sts_type sts,
   output rmbm_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_BYTE  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_BYTE;
            end
         end
         ST_BYTE: begin
            cmd.step = 1'b1;
            if (sts.stop) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/rmbm_datapath.sv =====
// Datapath: region lookup, per-byte checks, byte stores and response register.
// Depends on rmbm_pkg and rmbm_store.
module rmbm_datapath #(
   parameter int REGION_BYTES = 4096
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  rmbm_pkg::dp_cmd_type                                    cmd,
   output rmbm_pkg::dp_sts_type                                    sts,
   input  rmbm_pkg::region_cfg_type [rmbm_pkg::NUM_REGIONS-1:0]    cfg,
   input  logic [rmbm_pkg::FUNC_W-1:0]                             req_func,
   input  logic [rmbm_pkg::ADDR_W-1:0]                             req_address,
   input  logic [rmbm_pkg::LEN_W-1:0]                              req_access_bytes,
   input  logic [rmbm_pkg::DATA_W-1:0]                             req_write_data,
   input  logic                                                    rsp_tready,
   output logic                                                    rsp_tvalid,
   output logic [rmbm_pkg::DATA_W-1:0]                             rsp_read_data,
   output logic [rmbm_pkg::FAULT_W-1:0]                            rsp_fault,
   output logic                                                    rsp_address_mapped
);

   localparam int          OFF_W = $clog2(REGION_BYTES);
   localparam logic [31:0] DEPTH = 32'(REGION_BYTES);

   // request and progress registers
   logic [rmbm_pkg::FUNC_W-1:0]  func_ff;
   logic [rmbm_pkg::ADDR_W-1:0]  cur_addr_ff;
   logic [rmbm_pkg::LEN_W-1:0]   len_ff;
   logic [rmbm_pkg::DATA_W-1:0]  data_ff;
   logic [1:0]                   idx_ff;
   logic [rmbm_pkg::FAULT_W-1:0] fault_ff;
   logic                         mapped_ff;
   logic [rmbm_pkg::REG_W-1:0]   first_reg_ff;
   logic [OFF_W-1:0]             load_off_ff;
   logic [rmbm_pkg::DATA_W-1:0]  rdata_ff;
   logic                         pend_ff, pend_in;
   logic [1:0]                   pend_lane_ff;
   logic [rmbm_pkg::REG_W-1:0]   pend_reg_ff;
   logic [OFF_W-1:0]             clr_cnt_ff;

   // response register
   logic                         rsp_valid_ff;
   logic [rmbm_pkg::DATA_W-1:0]  rsp_rdata_ff;
   logic [rmbm_pkg::FAULT_W-1:0] rsp_fault_ff;
   logic                         rsp_mapped_ff;

   // lookup
   logic [31:0]                    eff   [rmbm_pkg::NUM_REGIONS];
   logic [31:0]                    offs  [rmbm_pkg::NUM_REGIONS];
   logic [rmbm_pkg::NUM_REGIONS-1:0] hit_r;
   logic                           hit;
   logic [rmbm_pkg::REG_W-1:0]     reg_sel;
   logic [31:0]                    lk_dist;
   logic [31:0]                    lk_eff;
   logic [rmbm_pkg::PERM_W-1:0]    lk_perms;

   // byte step decisions
   logic                         first;
   logic                         last_byte;
   logic                         len_ok;
   logic                         load_fit;
   logic                         stop;
   logic                         set_fault;
   logic [rmbm_pkg::FAULT_W-1:0] fault_val;
   logic                         wr_en;
   logic                         rd_en;
   logic [rmbm_pkg::REG_W-1:0]   acc_reg;
   logic [OFF_W-1:0]             acc_off;

   // store ports
   logic [OFF_W-1:0]            st_addr;
   logic [7:0]                  st_wdata;
   logic [7:0]                  st_rdata [rmbm_pkg::NUM_REGIONS];
   logic [rmbm_pkg::NUM_REGIONS-1:0] st_we;
   logic [rmbm_pkg::DATA_W-1:0] rdata_merge;

   // first matching region of the current byte address
   always_comb begin
      for (int r = 0; r < rmbm_pkg::NUM_REGIONS; r++) begin
         eff[r]   = (32'(cfg[r].size) > DEPTH) ? DEPTH : 32'(cfg[r].size);
         offs[r]  = cur_addr_ff - cfg[r].base;
         hit_r[r] = (cur_addr_ff >= cfg[r].base) && (cur_addr_ff < cfg[r].base + eff[r]);
      end
      reg_sel = '0;
      for (int r = rmbm_pkg::NUM_REGIONS - 1; r >= 0; r--) begin
         if (hit_r[r]) begin
            reg_sel = rmbm_pkg::REG_W'(r);
         end
      end
      hit      = |hit_r;
      lk_dist  = offs[reg_sel];
      lk_eff   = eff[reg_sel];
      lk_perms = cfg[reg_sel].perms;
   end

   // per-byte checks
   always_comb begin
      first     = (idx_ff == 2'd0);
      last_byte = (({1'b0, idx_ff} + 3'd1) == len_ff);
      len_ok    = (len_ff == 3'd1) || (len_ff == 3'd2) || (len_ff == 3'd4);
      load_fit  = (len_ff <= 3'd4) && ((lk_dist + 32'(len_ff)) <= lk_eff);
      stop      = 1'b0;
      set_fault = 1'b0;
      fault_val = rmbm_pkg::FAULT_NONE;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      acc_reg   = reg_sel;
      acc_off   = lk_dist[OFF_W-1:0];
      case (func_ff)
         rmbm_pkg::FUNC_READ: begin
            if ((first && !len_ok) || !hit || !lk_perms[rmbm_pkg::PERM_READ]) begin
               set_fault = 1'b1;
               fault_val = rmbm_pkg::FAULT_READ;
               stop      = 1'b1;
            end else begin
               rd_en = 1'b1;
               stop  = last_byte;
            end
         end
         rmbm_pkg::FUNC_WRITE: begin
            if ((first && !len_ok) || !hit || !lk_perms[rmbm_pkg::PERM_WRITE]) begin
               set_fault = 1'b1;
               fault_val = rmbm_pkg::FAULT_WRITE;
               stop      = 1'b1;
            end else begin
               wr_en = 1'b1;
               stop  = last_byte;
            end
         end
         rmbm_pkg::FUNC_LOAD: begin
            if (first) begin
               if (len_ff == 3'd0) begin
                  stop = 1'b1;
               end else if (!hit) begin
                  set_fault = 1'b1;
                  fault_val = rmbm_pkg::FAULT_UNMAPPED;
                  stop      = 1'b1;
               end else if (!load_fit) begin
                  set_fault = 1'b1;
                  fault_val = rmbm_pkg::FAULT_RANGE;
                  stop      = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  stop  = last_byte;
               end
            end else begin
               // later load bytes stay in the first byte's region
               wr_en   = 1'b1;
               acc_reg = first_reg_ff;
               acc_off = load_off_ff;
               stop    = last_byte;
            end
         end
         default: begin
            stop = 1'b1;
         end
      endcase
   end

   // merge the byte read in the previous cycle
   always_comb begin
      rdata_merge = rdata_ff;
      if (pend_ff) begin
         rdata_merge[pend_lane_ff*8 +: 8] = st_rdata[pend_reg_ff];
      end
   end

   // store port selection
   always_comb begin
      st_addr  = cmd.clear ? clr_cnt_ff : acc_off;
      st_wdata = cmd.clear ? 8'd0 : (data_ff[7:0] & rmbm_pkg::BYTE_MASK);
      for (int r = 0; r < rmbm_pkg::NUM_REGIONS; r++) begin
         st_we[r] = cmd.clear || (cmd.step && wr_en && (acc_reg == rmbm_pkg::REG_W'(r)));
      end
   end

   for (genvar g = 0; g < rmbm_pkg::NUM_REGIONS; g++) begin : g_store
      rmbm_store #(
         .DEPTH (REGION_BYTES)
      ) u_store (
         .clock (clock),
         .we    (st_we[g]),
         .addr  (st_addr),
         .wdata (st_wdata),
         .rdata (st_rdata[g])
      );
   end

   assign pend_in = cmd.step && rd_en;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (cmd.clear) begin
            clr_cnt_ff <= (clr_cnt_ff == OFF_W'(REGION_BYTES - 1)) ? '0 : clr_cnt_ff + 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request word and byte progress
   always_ff @(posedge clock) begin
      pend_lane_ff <= idx_ff;
      pend_reg_ff  <= acc_reg;
      rdata_ff     <= cmd.accept ? '0 : rdata_merge;
      if (cmd.accept) begin
         func_ff     <= req_func;
         cur_addr_ff <= req_address;
         len_ff      <= req_access_bytes;
         data_ff     <= req_write_data;
         idx_ff      <= 2'd0;
         fault_ff    <= rmbm_pkg::FAULT_NONE;
      end else if (cmd.step) begin
         cur_addr_ff <= cur_addr_ff + 32'd1;
         idx_ff      <= idx_ff + 2'd1;
         data_ff     <= data_ff >> 8;
         if (first) begin
            mapped_ff    <= hit;
            first_reg_ff <= reg_sel;
            load_off_ff  <= lk_dist[OFF_W-1:0] + 1'b1;
         end else begin
            load_off_ff  <= load_off_ff + 1'b1;
         end
         if (set_fault) begin
            fault_ff <= fault_val;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_rdata_ff  <= (fault_ff == rmbm_pkg::FAULT_NONE) ? rdata_merge : '0;
         rsp_fault_ff  <= fault_ff;
         rsp_mapped_ff <= mapped_ff;
      end
   end

   always_comb begin
      sts.clear_last = (clr_cnt_ff == OFF_W'(REGION_BYTES - 1));
      sts.stop       = stop;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_read_data      = rsp_rdata_ff;
   assign rsp_fault          = rsp_fault_ff;
   assign rsp_address_mapped = rsp_mapped_ff;

endmodule

// ===== design/region_mapped_byte_memory.sv =====
// Region mapped byte memory: a request stream in, one response word per request out,
// six region registers behind the configuration port. An access is accepted, then handles
// one byte at a time through the single port of the byte store, then hands the response
// to the output register once that register can take it; a fault ends the access at the
// faulting byte. The next request is taken while the response still waits in the output register.
// After reset the block clears both byte stores in one pass with req_tready low; the
// configuration port works during that pass.
// Depends on rmbm_pkg, rmbm_ctrl, rmbm_datapath and rmbm_store.
module region_mapped_byte_memory #(
   parameter int REGION_BYTES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tuser = func[1:0]
   // tdata = address[31:0], access_bytes[34:32], write_data[66:35], zero[71:67]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rmbm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [rmbm_pkg::FUNC_W-1:0]         req_tuser,
   // response: tdata = read_data[31:0], fault[34:32], address_mapped[35], zero[39:36]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rmbm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rmbm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rmbm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rmbm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   rmbm_pkg::region_cfg_type [rmbm_pkg::NUM_REGIONS-1:0] cfg_ff;
   rmbm_pkg::dp_cmd_type                                  cmd;
   rmbm_pkg::dp_sts_type                                  sts;

   logic                                csr_wr;
   logic [2:0]                          csr_idx;
   logic [rmbm_pkg::DATA_W-1:0]         rsp_read_data;
   logic [rmbm_pkg::FAULT_W-1:0]        rsp_fault;
   logic                                rsp_address_mapped;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // region registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0].base  <= '0;
         cfg_ff[0].size  <= 13'd4096;
         cfg_ff[0].perms <= 3'd7;
         cfg_ff[1].base  <= '0;
         cfg_ff[1].size  <= 13'd0;
         cfg_ff[1].perms <= 3'd7;
      end else if (csr_wr) begin
         case (csr_idx)
            rmbm_pkg::REG_R0_BASE:  cfg_ff[0].base  <= csr_pwdata;
            rmbm_pkg::REG_R0_SIZE:  cfg_ff[0].size  <= csr_pwdata[rmbm_pkg::SIZE_W-1:0];
            rmbm_pkg::REG_R0_PERMS: cfg_ff[0].perms <= csr_pwdata[rmbm_pkg::PERM_W-1:0];
            rmbm_pkg::REG_R1_BASE:  cfg_ff[1].base  <= csr_pwdata;
            rmbm_pkg::REG_R1_SIZE:  cfg_ff[1].size  <= csr_pwdata[rmbm_pkg::SIZE_W-1:0];
            rmbm_pkg::REG_R1_PERMS: cfg_ff[1].perms <= csr_pwdata[rmbm_pkg::PERM_W-1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (csr_idx)
         rmbm_pkg::REG_R0_BASE:  csr_prdata = cfg_ff[0].base;
         rmbm_pkg::REG_R0_SIZE:  csr_prdata = 32'(cfg_ff[0].size);
         rmbm_pkg::REG_R0_PERMS: csr_prdata = 32'(cfg_ff[0].perms);
         rmbm_pkg::REG_R1_BASE:  csr_prdata = cfg_ff[1].base;
         rmbm_pkg::REG_R1_SIZE:  csr_prdata = 32'(cfg_ff[1].size);
         rmbm_pkg::REG_R1_PERMS: csr_prdata = 32'(cfg_ff[1].perms);
         default:                csr_prdata = '0;
      endcase
   end

   rmbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rmbm_datapath #(
      .REGION_BYTES (REGION_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .cfg                (cfg_ff),
      .req_func           (req_tuser),
      .req_address        (req_tdata[31:0]),
      .req_access_bytes   (req_tdata[34:32]),
      .req_write_data     (req_tdata[66:35]),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_read_data      (rsp_read_data),
      .rsp_fault          (rsp_fault),
      .rsp_address_mapped (rsp_address_mapped)
   );

   assign rsp_tdata = {4'd0, rsp_address_mapped, rsp_fault, rsp_read_data};

endmodule
